[hdl/dfst_pkg.sv]
package dfst_pkg;

   // Field widths and storage limits
   localparam int VERTEX_W             = 6;
   localparam int VERT_CAP             = 64;
   localparam int MAX_VERTICES_DEFAULT = 64;

   // Request operation codes
   typedef logic [1:0] op_type;
   localparam op_type OP_ADD    = 2'd0;
   localparam op_type OP_SEARCH = 2'd1;
   localparam op_type OP_CLEAR  = 2'd2;

   // Priority encoder: index of the lowest set bit, zero when none is set
   function automatic logic [VERTEX_W-1:0] lowest_set(input logic [VERT_CAP-1:0] bits);
      logic [VERTEX_W-1:0] idx;
      idx = '0;
      for (int i = VERT_CAP - 1; i >= 0; i--) begin
         if (bits[i]) begin
            idx = VERTEX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

[hdl/dfst_adj_store.sv]
module dfst_adj_store #(
   parameter int VERT_LIMIT = dfst_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear_rows,
   input  logic                          rd_en,
   input  logic [$clog2(VERT_LIMIT)-1:0] rd_addr,
   input  logic                          wr_en,
   input  logic [$clog2(VERT_LIMIT)-1:0] wr_addr,
   input  logic [VERT_LIMIT-1:0]         wr_data,
   output logic [VERT_LIMIT-1:0]         rd_row
);
   import dfst_pkg::*;

   logic [VERT_LIMIT-1:0] adj_mem [VERT_LIMIT];
   logic [VERT_LIMIT-1:0] row_valid_ff;
   logic [VERT_LIMIT-1:0] row_valid_in;
   logic [VERT_LIMIT-1:0] rd_data_ff;
   logic                  rd_valid_ff;

   // Row valid bits: a row never written since the last clear reads as empty
   always_comb begin
      row_valid_in = row_valid_ff;
      if (clear_rows) begin
         row_valid_in = '0;
      end else if (wr_en) begin
         row_valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else begin
         row_valid_ff <= row_valid_in;
      end
   end

   // Adjacency memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         adj_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= adj_mem[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   assign rd_row = rd_valid_ff ? rd_data_ff : '0;

endmodule

[hdl/dfs_spanning_tree_edges_top.sv]
// Add edge: item taken in IDLE, then row read-modify-write in ADD_RD, ADD_WA, ADD_WB.
// Clear: taken in IDLE; row valid bits drop at once. Unused code: taken in IDLE.
// Search: each DFS step reads an adjacency row (S_RD), then priority-encodes
// that row (S_EVAL); a backtrack reads the stack, then the row (S_POP).
// One item at a time. Synchronous active-high reset empties the graph at once.
module dfs_spanning_tree_edges_top #(
   parameter int MAX_VERTICES = dfst_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  dfst_pkg::op_type              req_operation,
   input  logic [dfst_pkg::VERTEX_W-1:0] req_vertex_a,
   input  logic [dfst_pkg::VERTEX_W-1:0] req_vertex_b,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dfst_pkg::VERTEX_W-1:0] rsp_parent_vertex,
   output logic [dfst_pkg::VERTEX_W-1:0] rsp_child_vertex,
   output logic                          rsp_is_edge,
   output logic                          rsp_last
);
   import dfst_pkg::*;

   localparam int VERT_LIMIT = (MAX_VERTICES < VERT_CAP) ? MAX_VERTICES : VERT_CAP;
   localparam int VIDX_W     = $clog2(VERT_LIMIT);
   localparam int DEP_W      = $clog2(VERT_LIMIT + 1);
   localparam int CMP_W      = VERTEX_W + 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ADD_RD = 3'd1;
   localparam logic [2:0] ST_ADD_WA = 3'd2;
   localparam logic [2:0] ST_ADD_WB = 3'd3;
   localparam logic [2:0] ST_S_RD   = 3'd4;
   localparam logic [2:0] ST_S_EVAL = 3'd5;
   localparam logic [2:0] ST_S_POP  = 3'd6;
   localparam logic [2:0] ST_S_FIN  = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [VIDX_W-1:0]     a_ff, a_in;
   logic [VIDX_W-1:0]     b_ff, b_in;
   logic [VERTEX_W-1:0]   root_ff, root_in;
   logic [VIDX_W-1:0]     top_ff, top_in;
   logic [DEP_W-1:0]      depth_ff, depth_in;
   logic [VERT_LIMIT-1:0] visited_ff, visited_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [VIDX_W-1:0]     pend_parent_ff, pend_parent_in;
   logic [VIDX_W-1:0]     pend_child_ff, pend_child_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VERTEX_W-1:0]   rsp_parent_ff, rsp_parent_in;
   logic [VERTEX_W-1:0]   rsp_child_ff, rsp_child_in;
   logic                  rsp_is_edge_ff, rsp_is_edge_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  adj_clear;
   logic                  adj_rd_en;
   logic [VIDX_W-1:0]     adj_rd_addr;
   logic                  adj_wr_en;
   logic [VIDX_W-1:0]     adj_wr_addr;
   logic [VERT_LIMIT-1:0] adj_wr_data;
   logic [VERT_LIMIT-1:0] adj_row;

   logic [VIDX_W-1:0]     stack_mem [VERT_LIMIT];
   logic                  stk_wr_en;
   logic [VIDX_W-1:0]     stk_wr_addr;
   logic [VIDX_W-1:0]     stk_wr_data;
   logic                  stk_rd_en;
   logic [VIDX_W-1:0]     stk_rd_addr;
   logic [VIDX_W-1:0]     stk_q_ff;

   logic                  a_ok, b_ok;
   logic                  out_free;
   logic [VERT_LIMIT-1:0] cand;
   logic [VERTEX_W-1:0]   low_idx;
   logic [VIDX_W-1:0]     next_v;
   logic [DEP_W-1:0]      depth_m2;

   dfst_adj_store #(
      .VERT_LIMIT (VERT_LIMIT)
   ) u_adj (
      .clock      (clock),
      .reset      (reset),
      .clear_rows (adj_clear),
      .rd_en      (adj_rd_en),
      .rd_addr    (adj_rd_addr),
      .wr_en      (adj_wr_en),
      .wr_addr    (adj_wr_addr),
      .wr_data    (adj_wr_data),
      .rd_row     (adj_row)
   );

   // Decode request and search step helpers
   assign a_ok     = {1'b0, req_vertex_a} < CMP_W'(VERT_LIMIT);
   assign b_ok     = {1'b0, req_vertex_b} < CMP_W'(VERT_LIMIT);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cand     = adj_row & ~visited_ff;
   assign low_idx  = lowest_set(VERT_CAP'(cand));
   assign next_v   = low_idx[VIDX_W-1:0];
   assign depth_m2 = depth_ff - DEP_W'(2);

   assign req_stall = (state_ff != ST_IDLE);

   // Sequencer: edge updates, DFS steps and result hand-off
   always_comb begin
      state_in       = state_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      root_in        = root_ff;
      top_in         = top_ff;
      depth_in       = depth_ff;
      visited_in     = visited_ff;
      pend_valid_in  = pend_valid_ff;
      pend_parent_in = pend_parent_ff;
      pend_child_in  = pend_child_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_parent_in  = rsp_parent_ff;
      rsp_child_in   = rsp_child_ff;
      rsp_is_edge_in = rsp_is_edge_ff;
      rsp_last_in    = rsp_last_ff;

      adj_clear   = 1'b0;
      adj_rd_en   = 1'b0;
      adj_rd_addr = top_ff;
      adj_wr_en   = 1'b0;
      adj_wr_addr = a_ff;
      adj_wr_data = adj_row | (VERT_LIMIT'(1) << b_ff);

      stk_wr_en   = 1'b0;
      stk_wr_addr = depth_ff[VIDX_W-1:0];
      stk_wr_data = next_v;
      stk_rd_en   = 1'b0;
      stk_rd_addr = depth_m2[VIDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_operation)
                  OP_ADD: begin
                     a_in = req_vertex_a[VIDX_W-1:0];
                     b_in = req_vertex_b[VIDX_W-1:0];
                     if (a_ok && b_ok && (req_vertex_a != req_vertex_b)) begin
                        state_in = ST_ADD_RD;
                     end
                  end
                  OP_SEARCH: begin
                     root_in       = req_vertex_a;
                     pend_valid_in = 1'b0;
                     visited_in    = '0;
                     depth_in      = '0;
                     state_in      = ST_S_FIN;
                     if (a_ok) begin
                        visited_in  = VERT_LIMIT'(1) << req_vertex_a[VIDX_W-1:0];
                        stk_wr_en   = 1'b1;
                        stk_wr_addr = '0;
                        stk_wr_data = req_vertex_a[VIDX_W-1:0];
                        depth_in    = DEP_W'(1);
                        top_in      = req_vertex_a[VIDX_W-1:0];
                        state_in    = ST_S_RD;
                     end
                  end
                  OP_CLEAR: begin
                     adj_clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_ADD_RD: begin
            adj_rd_en   = 1'b1;
            adj_rd_addr = a_ff;
            state_in    = ST_ADD_WA;
         end

         // Write back row a, fetch row b in the same cycle
         ST_ADD_WA: begin
            adj_wr_en   = 1'b1;
            adj_wr_addr = a_ff;
            adj_wr_data = adj_row | (VERT_LIMIT'(1) << b_ff);
            adj_rd_en   = 1'b1;
            adj_rd_addr = b_ff;
            state_in    = ST_ADD_WB;
         end

         ST_ADD_WB: begin
            adj_wr_en   = 1'b1;
            adj_wr_addr = b_ff;
            adj_wr_data = adj_row | (VERT_LIMIT'(1) << a_ff);
            state_in    = ST_IDLE;
         end

         ST_S_RD: begin
            adj_rd_en   = 1'b1;
            adj_rd_addr = top_ff;
            state_in    = ST_S_EVAL;
         end

         // Take the lowest unvisited neighbor, or pop when none is left; finish at the root
         ST_S_EVAL: begin
            if (cand != '0) begin
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in   = 1'b1;
                     rsp_parent_in  = VERTEX_W'(pend_parent_ff);
                     rsp_child_in   = VERTEX_W'(pend_child_ff);
                     rsp_is_edge_in = 1'b1;
                     rsp_last_in    = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_parent_in = top_ff;
                  pend_child_in  = next_v;
                  visited_in     = visited_ff | (VERT_LIMIT'(1) << next_v);
                  stk_wr_en      = 1'b1;
                  stk_wr_addr    = depth_ff[VIDX_W-1:0];
                  stk_wr_data    = next_v;
                  depth_in       = depth_ff + DEP_W'(1);
                  top_in         = next_v;
                  state_in       = ST_S_RD;
               end
            end else if (depth_ff == DEP_W'(1)) begin
               depth_in = '0;
               state_in = ST_S_FIN;
            end else begin
               depth_in    = depth_ff - DEP_W'(1);
               stk_rd_en   = 1'b1;
               stk_rd_addr = depth_m2[VIDX_W-1:0];
               state_in    = ST_S_POP;
            end
         end

         ST_S_POP: begin
            top_in      = stk_q_ff;
            adj_rd_en   = 1'b1;
            adj_rd_addr = stk_q_ff;
            state_in    = ST_S_EVAL;
         end

         // Emit the held result as last, or the empty result
         ST_S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (pend_valid_ff) begin
                  rsp_parent_in  = VERTEX_W'(pend_parent_ff);
                  rsp_child_in   = VERTEX_W'(pend_child_ff);
                  rsp_is_edge_in = 1'b1;
               end else begin
                  rsp_parent_in  = root_ff;
                  rsp_child_in   = '0;
                  rsp_is_edge_in = 1'b0;
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Search stack memory
   always_ff @(posedge clock) begin
      if (stk_wr_en) begin
         stack_mem[stk_wr_addr] <= stk_wr_data;
      end
      if (stk_rd_en) begin
         stk_q_ff <= stack_mem[stk_rd_addr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         depth_ff      <= '0;
         visited_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         depth_ff      <= depth_in;
         visited_ff    <= visited_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      a_ff           <= a_in;
      b_ff           <= b_in;
      root_ff        <= root_in;
      top_ff         <= top_in;
      pend_parent_ff <= pend_parent_in;
      pend_child_ff  <= pend_child_in;
      rsp_parent_ff  <= rsp_parent_in;
      rsp_child_ff   <= rsp_child_in;
      rsp_is_edge_ff <= rsp_is_edge_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_parent_vertex = rsp_parent_ff;
   assign rsp_child_vertex  = rsp_child_ff;
   assign rsp_is_edge       = rsp_is_edge_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

[bench/dfs_spanning_tree_edges_top_tb.sv]
module dfs_spanning_tree_edges_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dfst_pkg::*;

   localparam int VERT_LIMIT     = (MAX_VERTICES_DEFAULT < 64) ? MAX_VERTICES_DEFAULT : 64;
   localparam logic [63:0] VERTEX_MASK =
      (VERT_LIMIT >= 64) ? {64{1'b1}} : ((64'd1 << VERT_LIMIT) - 64'd1);
   localparam op_type OP_UNUSED  = 2'd3;
   localparam int DIRECTED_ROWS  = 21;
   localparam int RANDOM_ITEMS   = 450;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;
   localparam int DRAIN_CYCLES   = 20;

   typedef struct packed {
      logic [VERTEX_W-1:0] parent;
      logic [VERTEX_W-1:0] child;
      logic                is_edge;
      logic                last;
   } tree_edge_type;

   typedef struct packed {
      op_type              op;
      logic [VERTEX_W-1:0] a;
      logic [VERTEX_W-1:0] b;
      logic                typed;
      tree_edge_type       want;
   } stim_row_type;

   localparam tree_edge_type NO_RESULT = '0;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_stall;
   op_type              req_operation = OP_ADD;
   logic [VERTEX_W-1:0] req_vertex_a  = '0;
   logic [VERTEX_W-1:0] req_vertex_b  = '0;
   logic                rsp_valid;
   logic                rsp_stall     = 1'b0;
   logic [VERTEX_W-1:0] rsp_parent_vertex;
   logic [VERTEX_W-1:0] rsp_child_vertex;
   logic                rsp_is_edge;
   logic                rsp_last;

   // Shadow of the graph store and search state
   logic [63:0]         graph_rows [64];
   logic [63:0]         seen_marks;
   logic [VERTEX_W-1:0] dfs_stack [64];
   int                  dfs_depth;

   tree_edge_type expected_edges [$];
   stim_row_type  directed_rows [DIRECTED_ROWS];

   int            fail_count  = 0;
   int            fed_items   = 0;
   int            idle_cycles = 0;
   int            stall_left  = 0;
   int            stall_roll;
   bit            no_idle     = 1'b0;
   tree_edge_type got_edge;
   tree_edge_type want_edge;

   dfs_spanning_tree_edges_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_vertex_a      (req_vertex_a),
      .req_vertex_b      (req_vertex_b),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_parent_vertex (rsp_parent_vertex),
      .rsp_child_vertex  (rsp_child_vertex),
      .rsp_is_edge       (rsp_is_edge),
      .rsp_last          (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void flag_failure(string what);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("%0t: %s", $time, what);
      end
   endfunction

   // Apply one item to the shadow graph; a search queues its tree edges when record is set
   function automatic void predict_request(op_type op, logic [VERTEX_W-1:0] a,
                                           logic [VERTEX_W-1:0] b, bit record);
      tree_edge_type       pend;
      logic [63:0]         cand;
      logic [VERTEX_W-1:0] top;
      logic [VERTEX_W-1:0] nxt;
      int                  emitted;
      bit                  have_pend;
      if (op == OP_ADD) begin
         if (a < VERT_LIMIT && b < VERT_LIMIT && a != b) begin
            graph_rows[a][b] = 1'b1;
            graph_rows[b][a] = 1'b1;
         end
      end else if (op == OP_CLEAR) begin
         for (int i = 0; i < 64; i++) begin
            graph_rows[i] = '0;
         end
      end else if (op == OP_SEARCH) begin
         seen_marks = '0;
         dfs_depth  = 0;
         emitted    = 0;
         have_pend  = 1'b0;
         pend       = NO_RESULT;
         if (a < VERT_LIMIT) begin
            seen_marks[a] = 1'b1;
            dfs_stack[0]  = a;
            dfs_depth     = 1;
         end
         while (dfs_depth > 0) begin
            top  = dfs_stack[dfs_depth - 1];
            cand = graph_rows[top] & ~seen_marks & VERTEX_MASK;
            if (cand != '0) begin
               // take the lowest-numbered unvisited neighbor
               nxt = '0;
               for (int i = 0; i < 64; i++) begin
                  if (cand[i]) begin
                     nxt = VERTEX_W'(i);
                     break;
                  end
               end
               seen_marks[nxt] = 1'b1;
               if (emitted < 63) begin
                  if (have_pend && record) begin
                     expected_edges = {expected_edges, pend};
                  end
                  pend      = '{parent: top, child: nxt, is_edge: 1'b1, last: 1'b0};
                  have_pend = 1'b1;
                  emitted++;
               end
               if (dfs_depth < 64) begin
                  dfs_stack[dfs_depth] = nxt;
                  dfs_depth++;
               end
            end else begin
               dfs_depth--;
            end
         end
         // isolated or out-of-range root gives one empty result
         if (!have_pend) begin
            pend = '{parent: a, child: '0, is_edge: 1'b0, last: 1'b0};
         end
         pend.last = 1'b1;
         if (record) begin
            expected_edges = {expected_edges, pend};
         end
      end
   endfunction

   function automatic int pick_gap();
      int roll;
      if (no_idle) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Present one item and hold it until accepted; valid stays up for a
   // following item with no gap
   task automatic send_item(input op_type op, input logic [VERTEX_W-1:0] a,
                            input logic [VERTEX_W-1:0] b, input logic typed,
                            input tree_edge_type want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_vertex_a  <= a;
      req_vertex_b  <= b;
      do @(posedge clock); while (req_stall);
      predict_request(op, a, b, !typed);
      if (typed) begin
         expected_edges = {expected_edges, want};
      end
      if (op != OP_UNUSED) begin
         fed_items++;
      end
   endtask

   // Hold the sender until every queued result has come back
   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_edges.size() != 0);
   endtask

   // Check each accepted result, then pick the stall for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_edge = '{parent: rsp_parent_vertex, child: rsp_child_vertex,
                      is_edge: rsp_is_edge, last: rsp_last};
         if (expected_edges.size() == 0) begin
            flag_failure($sformatf("unexpected result parent=%0d child=%0d edge=%0b last=%0b",
                                   got_edge.parent, got_edge.child, got_edge.is_edge,
                                   got_edge.last));
         end else begin
            want_edge = expected_edges.pop_front();
            if (got_edge !== want_edge) begin
               flag_failure($sformatf({"result mismatch: expected parent=%0d child=%0d ",
                                       "edge=%0b last=%0b, got parent=%0d child=%0d ",
                                       "edge=%0b last=%0b"},
                                      want_edge.parent, want_edge.child,
                                      want_edge.is_edge, want_edge.last,
                                      got_edge.parent, got_edge.child,
                                      got_edge.is_edge, got_edge.last));
            end
         end
      end
      if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (no_idle || stall_roll < 60) begin
            rsp_stall <= 1'b0;
         end else if (stall_roll < 93) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
         end else begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(5, 40);
         end
      end
   end

   // Abort when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int order [64];
      int base;
      int span;
      int edges;
      int searches;
      int style;
      int roll;
      int pick;
      int swap_tmp;
      int paths_built;

      paths_built = 0;
      predict_request(OP_CLEAR, '0, '0, 1'b0);
      directed_rows = '{
         '{OP_SEARCH, 6'd0,  6'd0,  1'b1, '{6'd0,  6'd0,  1'b0, 1'b1}},
         '{OP_SEARCH, 6'd63, 6'd63, 1'b1, '{6'd63, 6'd0,  1'b0, 1'b1}},
         '{OP_ADD,    6'd0,  6'd63, 1'b0, NO_RESULT},
         '{OP_SEARCH, 6'd0,  6'd0,  1'b1, '{6'd0,  6'd63, 1'b1, 1'b1}},
         '{OP_SEARCH, 6'd63, 6'd0,  1'b1, '{6'd63, 6'd0,  1'b1, 1'b1}},
         '{OP_ADD,    6'd7,  6'd7,  1'b0, NO_RESULT},
         '{OP_SEARCH, 6'd7,  6'd0,  1'b1, '{6'd7,  6'd0,  1'b0, 1'b1}},
         '{OP_ADD,    6'd63, 6'd0,  1'b0, NO_RESULT},
         '{OP_UNUSED, 6'd63, 6'd63, 1'b0, NO_RESULT},
         '{OP_SEARCH, 6'd0,  6'd63, 1'b1, '{6'd0,  6'd63, 1'b1, 1'b1}},
         '{OP_ADD,    6'd1,  6'd2,  1'b0, NO_RESULT},
         '{OP_ADD,    6'd2,  6'd3,  1'b0, NO_RESULT},
         '{OP_ADD,    6'd1,  6'd3,  1'b0, NO_RESULT},
         '{OP_ADD,    6'd0,  6'd1,  1'b0, NO_RESULT},
         '{OP_SEARCH, 6'd0,  6'd0,  1'b0, NO_RESULT},
         '{OP_SEARCH, 6'd3,  6'd0,  1'b0, NO_RESULT},
         '{OP_ADD,    6'd42, 6'd21, 1'b0, NO_RESULT},
         '{OP_SEARCH, 6'd21, 6'd0,  1'b1, '{6'd21, 6'd42, 1'b1, 1'b1}},
         '{OP_CLEAR,  6'd63, 6'd63, 1'b0, NO_RESULT},
         '{OP_SEARCH, 6'd0,  6'd0,  1'b1, '{6'd0,  6'd0,  1'b0, 1'b1}},
         '{OP_SEARCH, 6'd42, 6'd0,  1'b1, '{6'd42, 6'd0,  1'b0, 1'b1}}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         send_item(directed_rows[r].op, directed_rows[r].a, directed_rows[r].b,
                   directed_rows[r].typed, directed_rows[r].want);
      end
      wait_drain();

      // Random phases: build a graph, then search it
      while (fed_items < DIRECTED_ROWS + RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 4) == 0);
         style   = $urandom_range(0, 9);
         if ($urandom_range(0, 2) == 0) begin
            send_item(OP_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                      1'b0, NO_RESULT);
         end
         if (style == 0 && paths_built < 2) begin
            // one path through all vertices in shuffled order: deepest stack
            for (int i = 0; i < 64; i++) begin
               order[i] = i;
            end
            for (int i = 63; i > 0; i--) begin
               pick        = $urandom_range(0, i);
               swap_tmp    = order[i];
               order[i]    = order[pick];
               order[pick] = swap_tmp;
            end
            send_item(OP_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                      1'b0, NO_RESULT);
            for (int i = 1; i < 64; i++) begin
               send_item(OP_ADD, 6'(order[i - 1]), 6'(order[i]), 1'b0, NO_RESULT);
            end
            send_item(OP_SEARCH, 6'(order[0]), 6'($urandom_range(0, 63)), 1'b0, NO_RESULT);
            send_item(OP_SEARCH, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                      1'b0, NO_RESULT);
            paths_built++;
         end else begin
            base  = $urandom_range(0, 63);
            span  = (style < 6) ? 8 : 64;
            edges = (style >= 8) ? $urandom_range(20, 60) : $urandom_range(1, 10);
            for (int k = 0; k < edges; k++) begin
               roll = $urandom_range(0, 19);
               if (roll == 0) begin
                  send_item(OP_UNUSED, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                            1'b0, NO_RESULT);
               end else if (roll == 1) begin
                  pick = $urandom_range(0, 63);
                  send_item(OP_ADD, 6'(pick), 6'(pick), 1'b0, NO_RESULT);
               end else if (roll == 2) begin
                  send_item(OP_SEARCH, 6'((base + $urandom_range(0, span - 1)) % 64),
                            6'($urandom_range(0, 63)), 1'b0, NO_RESULT);
               end else begin
                  send_item(OP_ADD, 6'((base + $urandom_range(0, span - 1)) % 64),
                            6'((base + $urandom_range(0, span - 1)) % 64), 1'b0, NO_RESULT);
               end
            end
            searches = $urandom_range(1, 3);
            for (int s = 0; s < searches; s++) begin
               if ($urandom_range(0, 3) == 0) begin
                  pick = $urandom_range(0, 63);
               end else begin
                  pick = (base + $urandom_range(0, span - 1)) % 64;
               end
               send_item(OP_SEARCH, 6'(pick), 6'($urandom_range(0, 63)), 1'b0, NO_RESULT);
            end
         end
         if ($urandom_range(0, 5) == 0) begin
            wait_drain();
         end
      end

      // Let the last results and any edge write finish
      wait_drain();
      no_idle = 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_edges.size() != 0) begin
         flag_failure($sformatf("%0d results never arrived", expected_edges.size()));
      end
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/dfst_pkg.sv
hdl/dfst_adj_store.sv
hdl/dfs_spanning_tree_edges_top.sv
bench/dfs_spanning_tree_edges_top_tb.sv
